// ===== sv/sha_pkg.sv =====
// Package with the SHA-256 constants, types and round functions.
package sha_pkg;

	localparam int unsigned FifoDepth = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	// Padding phases of the input side.
	typedef enum logic [1:0] {
		PH_READ,
		PH_MARK,
		PH_FILL,
		PH_LEN
	} phase_t;

	localparam logic [255:0] InitHash = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] init_word(input logic [2:0] idx);
		return InitHash[{idx, 5'd0} +: 32];
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		case (t)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

endpackage

// ===== sv/sha_front.sv =====
// Input side: takes message words, pads the final word and queues block words.
module sha_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [39:0]     s_tdata,
	input  logic            s_tlast,
	output logic            q_valid,
	input  logic            q_ready,
	output logic [31:0]     q_word,
	output logic            q_final
);

	localparam int unsigned PtrW = $clog2(sha_pkg::FifoDepth);

	sha_pkg::phase_t phase_q, phase_d;
	logic [63:0]    len_q;
	logic [3:0]     pos_q;
	logic           len_lo_q;
	logic [31:0]    fifo_q [sha_pkg::FifoDepth];
	logic           fin_q [sha_pkg::FifoDepth];
	logic [PtrW:0]  wr_q;
	logic [PtrW:0]  rd_q;
	logic           full;
	logic           push;
	logic [31:0]    push_word;
	logic           push_fin;
	logic [2:0]     cnt;
	logic [31:0]    keep;
	logic [31:0]    mark;
	logic [63:0]    len_next;

	assign full = (wr_q[PtrW] != rd_q[PtrW]) && (wr_q[PtrW-1:0] == rd_q[PtrW-1:0]);
	assign q_valid = wr_q != rd_q;
	assign q_word = fifo_q[rd_q[PtrW-1:0]];
	assign q_final = fin_q[rd_q[PtrW-1:0]];
	assign s_tready = (phase_q == sha_pkg::PH_READ) && !full;

	// Word generation and next phase for the current phase.
	always_comb begin
		cnt = (!s_tlast || s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
		keep = (cnt == 3'd0) ? 32'h0 : (32'hffffffff << {(3'd4 - cnt), 3'd0});
		mark = (cnt == 3'd4) ? 32'h0 : (32'h80 << {(3'd3 - cnt), 3'd0});
		len_next = len_q + {58'd0, cnt, 3'd0};
		push = 1'b0;
		push_word = 32'h0;
		push_fin = 1'b0;
		phase_d = phase_q;
		case (phase_q)
			sha_pkg::PH_READ: begin
				push = s_tvalid && !full;
				push_word = (s_tdata[31:0] & keep) | mark;
				if (push && s_tlast) begin
					if (cnt == 3'd4) phase_d = sha_pkg::PH_MARK;
					else if (pos_q == 4'd13) phase_d = sha_pkg::PH_LEN;
					else phase_d = sha_pkg::PH_FILL;
				end
			end
			sha_pkg::PH_MARK: begin
				push = !full;
				push_word = 32'h80000000;
				if (push) begin
					if (pos_q == 4'd13) phase_d = sha_pkg::PH_LEN;
					else phase_d = sha_pkg::PH_FILL;
				end
			end
			sha_pkg::PH_FILL: begin
				push = !full;
				if (push && pos_q == 4'd13) phase_d = sha_pkg::PH_LEN;
			end
			sha_pkg::PH_LEN: begin
				push = !full;
				push_word = len_lo_q ? len_q[31:0] : len_q[63:32];
				push_fin = len_lo_q;
				if (push && len_lo_q) phase_d = sha_pkg::PH_READ;
			end
			default: phase_d = sha_pkg::PH_READ;
		endcase
	end

	// Phase, length and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sha_pkg::PH_READ;
			len_q <= 64'd0;
			pos_q <= 4'd0;
			len_lo_q <= 1'b0;
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (q_valid && q_ready) rd_q <= rd_q + 1'b1;
			if (push) begin
				wr_q <= wr_q + 1'b1;
				pos_q <= pos_q + 4'd1;
				if (phase_q == sha_pkg::PH_READ) len_q <= len_next;
				if (phase_q == sha_pkg::PH_LEN) begin
					len_lo_q <= !len_lo_q;
					if (len_lo_q) len_q <= 64'd0;
				end
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q[PtrW-1:0]] <= push_word;
			fin_q[wr_q[PtrW-1:0]] <= push_fin;
		end
	end

endmodule

// ===== sv/sha_back.sv =====
// Compression side: collects 16-word blocks, runs 64 rounds and emits the digest.
module sha_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [31:0]   q_word,
	input  logic          q_final,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [39:0]   m_tdata,
	output logic          m_tlast,
	output logic          busy
);

	sha_pkg::state_t state_q, state_d;
	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [3:0]   fill_q;
	logic [5:0]   t_q;
	logic         fin_q;
	logic [2:0]   oidx_q;
	logic [31:0]  wt, s0w, s1w, s1, ch, t1, s0, mj;

	assign q_ready = (state_q == sha_pkg::ST_IDLE);
	assign busy = (state_q != sha_pkg::ST_IDLE) || (fill_q != 4'd0);
	assign m_tvalid = (state_q == sha_pkg::ST_OUT);
	assign m_tdata = {5'd0, oidx_q, h_q[oidx_q]};
	assign m_tlast = (oidx_q == 3'd7);

	// Round datapath: schedule word is w_q[0], the window shifts each round.
	always_comb begin
		wt = w_q[0];
		s0w = sha_pkg::rotr(w_q[1], 7) ^ sha_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1w = sha_pkg::rotr(w_q[14], 17) ^ sha_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		s1 = sha_pkg::rotr(v_q[4], 6) ^ sha_pkg::rotr(v_q[4], 11) ^ sha_pkg::rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + sha_pkg::round_k(t_q) + wt;
		s0 = sha_pkg::rotr(v_q[0], 2) ^ sha_pkg::rotr(v_q[0], 13) ^ sha_pkg::rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha_pkg::ST_IDLE: if (q_valid && fill_q == 4'd15) state_d = sha_pkg::ST_ROUND;
			sha_pkg::ST_ROUND: if (t_q == 6'd63) state_d = sha_pkg::ST_FOLD;
			sha_pkg::ST_FOLD: state_d = fin_q ? sha_pkg::ST_OUT : sha_pkg::ST_IDLE;
			sha_pkg::ST_OUT: if (m_tready && oidx_q == 3'd7) state_d = sha_pkg::ST_IDLE;
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha_pkg::ST_IDLE;
			fill_q <= 4'd0;
			t_q <= 6'd0;
			fin_q <= 1'b0;
			oidx_q <= 3'd0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_word(3'(i));
		end else begin
			state_q <= state_d;
			case (state_q)
				sha_pkg::ST_IDLE: begin
					if (q_valid) begin
						fill_q <= fill_q + 4'd1;
						if (fill_q == 4'd15) begin
							fin_q <= q_final;
							t_q <= 6'd0;
						end
					end
				end
				sha_pkg::ST_ROUND: t_q <= t_q + 6'd1;
				sha_pkg::ST_FOLD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
				end
				sha_pkg::ST_OUT: begin
					if (m_tready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7)
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::init_word(3'(i));
					end
				end
				default: t_q <= 6'd0;
			endcase
		end
	end

	// Block window, working variables.
	always_ff @(posedge clk) begin
		if (state_q == sha_pkg::ST_IDLE && q_valid) begin
			w_q[fill_q] <= q_word;
			if (fill_q == 4'd15)
				for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (state_q == sha_pkg::ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= s1w + w_q[9] + s0w + w_q[0];
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + s0 + mj;
		end
	end

endmodule

// ===== sv/sha256_hash_engine_core.sv =====
// Streaming SHA-256 engine top level: front padding unit, word queue and compression unit.
// Each 16-word block is collected from the queue, then runs 64 rounds and one fold step in
// the single round unit, which sets the throughput; no block word is taken meanwhile.
// After a last word, one or two blocks run, then eight digest transactions follow.
// Reset (arst_n low, asynchronous) returns the hash words to the initial values
// and clears the length, position, queue and all control state.
module sha256_hash_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // msg_word [31:0], byte_count [34:32], zero fill
	input  logic        s_tlast,  // last_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word [31:0], word_index [34:32], zero fill
	output logic        m_tlast   // digest_last
);

	logic        q_valid, q_ready, q_final, busy;
	logic [31:0] q_word;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.q_valid(q_valid), .q_ready(q_ready), .q_word(q_word), .q_final(q_final)
	);

	sha_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_word(q_word), .q_final(q_final),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.busy(busy)
	);

`ifndef ASSERT_OFF
	// A digest is only shown while the compression side is busy.
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> busy) else $error("digest without busy back end");
	// On the last digest word the word index field is seven.
	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata[34:32] == 3'd7)) else $error("bad last index");
	// The index advances after each digest transaction that is not the last.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid &&
		m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)) else $error("index skipped");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the streaming SHA-256 engine core.
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned RandItems = 280;
	localparam int unsigned CycleLimit = 400000;

	// One row of the directed stimulus; a typed digest of zero means predictor only.
	typedef struct {
		logic [31:0] word;
		logic [2:0]  nbytes;
		logic        last;
		logic [31:0] digest0;
	} stim_row_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        fin;
	} digest_item_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	// Predictor state.
	logic [31:0] hash_st[8];
	logic [31:0] blk_buf[16];
	logic [63:0] msg_bits;
	int unsigned blk_pos;

	digest_item_t digest_q[$];
	int unsigned  n_errors;
	int unsigned  n_digests;
	int unsigned  n_words;
	int unsigned  cycle_cnt;

	stim_row_t dir_rows[$];

	sha256_hash_engine_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock generation.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] ror32(logic [31:0] v, int unsigned n);
		return (v >> n) | (v << (32 - n));
	endfunction

	function automatic logic [31:0] k_const(int unsigned t);
		logic [31:0] tab[64] = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
			32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
			32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
			32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
			32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return tab[t];
	endfunction

	task automatic clear_hash();
		hash_st = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		msg_bits = '0;
		blk_pos = 0;
	endtask

	// Sixty-four rounds over the buffered block, folded into the running hash.
	task automatic compress_blk();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2;
		for (int t = 0; t < 64; t++) begin
			if (t < 16) begin
				w[t] = blk_buf[t];
			end else begin
				w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
					+ (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
			end
		end
		v = hash_st;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
	endtask

	task automatic append_word(logic [31:0] w);
		blk_buf[blk_pos] = w;
		blk_pos++;
		if (blk_pos == 16) begin
			compress_blk();
			blk_pos = 0;
		end
	endtask

	// Absorbs one accepted word; on a last word pads, finishes and queues the digest.
	task automatic absorb_word(logic [31:0] w, logic [2:0] nb, logic last);
		int unsigned cnt;
		logic [31:0] keep;
		digest_item_t d;
		cnt = (!last || nb > 4) ? 4 : nb;
		msg_bits += 64'(cnt * 8);
		if (!last) begin
			append_word(w);
			return;
		end
		if (cnt == 4) begin
			append_word(w);
			append_word(32'h80000000);
		end else begin
			keep = (cnt == 0) ? 32'h0 : (32'hffffffff << (8 * (4 - cnt)));
			append_word((w & keep) | (32'h80 << (8 * (3 - cnt))));
		end
		while (blk_pos != 14) append_word(32'h0);
		append_word(msg_bits[63:32]);
		append_word(msg_bits[31:0]);
		for (int i = 0; i < 8; i++) begin
			d.word = hash_st[i];
			d.idx = 3'(i);
			d.fin = (i == 7);
			digest_q.push_back(d);
		end
		clear_hash();
	endtask

	// Drives one word through the input handshake with a random lead-in gap.
	task automatic send_word(logic [31:0] w, logic [2:0] nb, logic last);
		int unsigned gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, nb, w};
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		absorb_word(w, nb, last);
		n_words++;
		@(negedge clk);
	endtask

	// Output side: a random wait before each digest word, compare against the oldest expectation.
	initial begin
		digest_item_t e;
		int unsigned hold;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = $urandom_range(0, 3);
			if (hold != 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest word %h", $time, m_tdata);
				n_errors++;
			end else begin
				e = digest_q.pop_front();
				n_digests++;
				if (m_tdata[31:0] !== e.word || m_tdata[34:32] !== e.idx
						|| m_tlast !== e.fin || m_tdata[39:35] !== 5'd0) begin
					$display("%0t: digest mismatch expected %h idx %0d last %b, got %h idx %0d last %b",
						$time, e.word, e.idx, e.fin, m_tdata[31:0], m_tdata[34:32], m_tlast);
					n_errors++;
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CycleLimit) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		int unsigned mlen;
		digest_item_t e;
		n_errors = 0; n_digests = 0; n_words = 0; cycle_cnt = 0;
		s_tvalid = 1'b0; s_tdata = '0; s_tlast = 1'b0;
		arst_n = 1'b0;
		clear_hash();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty message, "abc", byte counts 1..7, zero and all-ones words, a message that pads into two blocks.
		dir_rows.push_back('{32'h0, 3'd0, 1'b1, 32'he3b0c442});
		dir_rows.push_back('{32'h61626300, 3'd3, 1'b1, 32'hba7816bf});
		dir_rows.push_back('{32'hffffffff, 3'd1, 1'b1, 32'h0});
		dir_rows.push_back('{32'hffffffff, 3'd2, 1'b1, 32'h0});
		dir_rows.push_back('{32'hffffffff, 3'd4, 1'b1, 32'h0});
		dir_rows.push_back('{32'h12345678, 3'd5, 1'b0, 32'h0});
		dir_rows.push_back('{32'hffffffff, 3'd7, 1'b1, 32'h0});
		dir_rows.push_back('{32'h0, 3'd6, 1'b1, 32'h0});
		for (int i = 0; i < 14; i++) dir_rows.push_back('{32'(i * 32'h11111111), 3'd7, 1'b0, 32'h0});
		dir_rows.push_back('{32'hdeadbeef, 3'd3, 1'b1, 32'h0});
		foreach (dir_rows[r]) begin
			if (dir_rows[r].last && dir_rows[r].digest0 != 32'h0) begin
				absorb_word(dir_rows[r].word, dir_rows[r].nbytes, 1'b1);
				e = digest_q[digest_q.size() - 8];
				if (e.word !== dir_rows[r].digest0) begin
					$display("%0t: known digest expected %h predicted %h", $time,
						dir_rows[r].digest0, e.word);
					n_errors++;
				end
				clear_hash();
				for (int i = 0; i < 8; i++) void'(digest_q.pop_back());
			end
			send_word(dir_rows[r].word, dir_rows[r].nbytes, dir_rows[r].last);
		end

		// Hold off until every digest word has come back.
		s_tvalid <= 1'b0;
		while (digest_q.size() != 0) @(negedge clk);

		// Random messages, mostly short, a few spanning several blocks.
		while (n_words < RandItems) begin
			mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 40) : $urandom_range(0, 15);
			for (int i = 0; i < mlen; i++)
				send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
			send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
		end
		s_tvalid <= 1'b0;

		while (digest_q.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		$display("Sent %0d message words, checked %0d digest words.", n_words, n_digests);
		if (n_errors == 0 && digest_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
